@@ sv/lga_pkg.sv @@
// ============================================================================
// lga_pkg
// Shared types and constants of the landmark gated association block.
// ============================================================================
package lga_pkg;

    localparam int COORD_W = 24;
    localparam int TRIG_W  = 16;
    localparam int GATE_W  = 32;
    localparam int SLOT_W  = 8;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 3;

    localparam int PROD_W  = COORD_W + TRIG_W;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int ROT_W   = DIFF_W - 14;
    localparam int WSUM_W  = ROT_W + 1;
    localparam int DELTA_W = COORD_W + 1;
    localparam int SQ_W    = 2 * DELTA_W;
    localparam int DIST_W  = SQ_W + 1;

    localparam logic       OPC_POSE = 1'b0;
    localparam logic       OPC_CONE = 1'b1;

    localparam logic [GATE_W-1:0]        GATE_RESET = 32'd16384;
    localparam logic signed [TRIG_W-1:0] COS_RESET  = 16'sd16384;
    localparam logic [DIFF_W-1:0]        ROUND_HALF = 41'd8192;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROUND,
        ST_WORLD,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic pose_load;
        logic cone_load;
        logic scan_start;
        logic scan_en;
        logic res_match;
        logic res_append;
        logic res_full;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic issue_done;
        logic pipe_busy;
        logic hit;
        logic room;
    } sts_t;

endpackage

@@ sv/lga_ctrl.sv @@
// ============================================================================
// lga_ctrl
// Controller that sequences the transform, the table scan and the result.
// ============================================================================
module lga_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_opcode,
    output logic           in_ready,
    input  logic           out_ready,
    output logic           out_valid,
    input  lga_pkg::sts_t  sts,
    output lga_pkg::cmd_t  cmd
);

    lga_pkg::state_t state_reg;
    lga_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lga_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lga_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_opcode == lga_pkg::OPC_POSE)
                    begin
                        cmd.pose_load = 1'b1;
                    end
                    else
                    begin
                        cmd.cone_load = 1'b1;
                        state_next    = lga_pkg::ST_MUL;
                    end
                end
            end
            lga_pkg::ST_MUL:
            begin
                state_next = lga_pkg::ST_ROUND;
            end
            lga_pkg::ST_ROUND:
            begin
                state_next = lga_pkg::ST_WORLD;
            end
            lga_pkg::ST_WORLD:
            begin
                cmd.scan_start = 1'b1;
                state_next     = lga_pkg::ST_SCAN;
            end
            lga_pkg::ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.hit)
                begin
                    cmd.res_match = 1'b1;
                    state_next    = lga_pkg::ST_DONE;
                end
                else if (sts.issue_done && !sts.pipe_busy)
                begin
                    if (sts.room)
                    begin
                        cmd.res_append = 1'b1;
                    end
                    else
                    begin
                        cmd.res_full = 1'b1;
                    end
                    state_next = lga_pkg::ST_DONE;
                end
            end
            lga_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lga_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lga_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_ready  = (state_reg == lga_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.res_match, cmd.res_append, cmd.res_full}))
        else $error("More than one scan outcome in a cycle.");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_append |-> sts.room)
        else $error("Append requested with a full table.");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("Output register overwritten before its transaction.");
`endif

endmodule

@@ sv/lga_dp.sv @@
// ============================================================================
// lga_dp
// Datapath: pose registers, heading transform, landmark memory and gate scan.
// ============================================================================
module lga_dp
#(
    parameter int MAX_LANDMARKS = 256
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  lga_pkg::cmd_t                      cmd,
    output lga_pkg::sts_t                      sts,
    input  logic [lga_pkg::IN_DATA_W-1:0]      in_data,
    input  logic                               cfg_valid,
    input  logic [lga_pkg::GATE_W-1:0]         cfg_data,
    output logic [lga_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [lga_pkg::OUT_USER_W-1:0]     out_flags
);

    localparam int IDX_W = $clog2(MAX_LANDMARKS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LANDMARKS);

    logic [lga_pkg::GATE_W-1:0]          gate_reg;
    logic signed [lga_pkg::COORD_W-1:0]  robot_x_reg;
    logic signed [lga_pkg::COORD_W-1:0]  robot_y_reg;
    logic signed [lga_pkg::TRIG_W-1:0]   yaw_cos_reg;
    logic signed [lga_pkg::TRIG_W-1:0]   yaw_sin_reg;
    logic signed [lga_pkg::COORD_W-1:0]  lx_reg;
    logic signed [lga_pkg::COORD_W-1:0]  ly_reg;

    logic signed [lga_pkg::PROD_W-1:0]   p_cx_reg;
    logic signed [lga_pkg::PROD_W-1:0]   p_sy_reg;
    logic signed [lga_pkg::PROD_W-1:0]   p_sx_reg;
    logic signed [lga_pkg::PROD_W-1:0]   p_cy_reg;
    logic signed [lga_pkg::DIFF_W-1:0]   sum_x;
    logic signed [lga_pkg::DIFF_W-1:0]   sum_y;
    logic signed [lga_pkg::ROT_W-1:0]    rot_x_reg;
    logic signed [lga_pkg::ROT_W-1:0]    rot_y_reg;
    logic signed [lga_pkg::WSUM_W-1:0]   wsum_x;
    logic signed [lga_pkg::WSUM_W-1:0]   wsum_y;
    logic signed [lga_pkg::COORD_W-1:0]  wx_reg;
    logic signed [lga_pkg::COORD_W-1:0]  wy_reg;
    logic signed [lga_pkg::COORD_W-1:0]  wx_next;
    logic signed [lga_pkg::COORD_W-1:0]  wy_next;

    logic [2*lga_pkg::COORD_W-1:0]       lm_mem [MAX_LANDMARKS];
    logic [2*lga_pkg::COORD_W-1:0]       rdata_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    scan_idx_reg;
    logic                                issue;

    logic                                v1_reg;
    logic                                v2_reg;
    logic                                v3_reg;
    logic                                v4_reg;
    logic [IDX_W-1:0]                    idx1_reg;
    logic [IDX_W-1:0]                    idx2_reg;
    logic [IDX_W-1:0]                    idx3_reg;
    logic [IDX_W-1:0]                    idx4_reg;
    logic signed [lga_pkg::DELTA_W-1:0]  dx_reg;
    logic signed [lga_pkg::DELTA_W-1:0]  dy_reg;
    logic signed [lga_pkg::SQ_W-1:0]     sqx_reg;
    logic signed [lga_pkg::SQ_W-1:0]     sqy_reg;
    logic [lga_pkg::DIST_W-1:0]          dist_sq;
    logic                                hit4_reg;

    logic                                matched_reg;
    logic                                added_reg;
    logic                                full_reg;
    logic [IDX_W-1:0]                    slot_reg;
    logic [lga_pkg::OUT_DATA_W-1:0]      out_data_reg;
    logic [lga_pkg::OUT_USER_W-1:0]      out_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg    <= lga_pkg::GATE_RESET;
            robot_x_reg <= '0;
            robot_y_reg <= '0;
            yaw_cos_reg <= lga_pkg::COS_RESET;
            yaw_sin_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gate_reg <= cfg_data;
            end
            if (cmd.pose_load)
            begin
                robot_x_reg <= in_data[23:0];
                robot_y_reg <= in_data[47:24];
                yaw_cos_reg <= in_data[63:48];
                yaw_sin_reg <= in_data[79:64];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cone_load)
        begin
            lx_reg <= in_data[103:80];
            ly_reg <= in_data[127:104];
        end
        p_cx_reg  <= yaw_cos_reg * lx_reg;
        p_sy_reg  <= yaw_sin_reg * ly_reg;
        p_sx_reg  <= yaw_sin_reg * lx_reg;
        p_cy_reg  <= yaw_cos_reg * ly_reg;
        rot_x_reg <= sum_x[lga_pkg::DIFF_W-1:14];
        rot_y_reg <= sum_y[lga_pkg::DIFF_W-1:14];
        wx_reg    <= wx_next;
        wy_reg    <= wy_next;
    end

    // Rounding adds one half before the arithmetic shift, so ties go upward.
    assign sum_x = lga_pkg::DIFF_W'(p_cx_reg) - lga_pkg::DIFF_W'(p_sy_reg)
                 + $signed(lga_pkg::ROUND_HALF);
    assign sum_y = lga_pkg::DIFF_W'(p_sx_reg) + lga_pkg::DIFF_W'(p_cy_reg)
                 + $signed(lga_pkg::ROUND_HALF);

    assign wsum_x = lga_pkg::WSUM_W'(robot_x_reg) + lga_pkg::WSUM_W'(rot_x_reg);
    assign wsum_y = lga_pkg::WSUM_W'(robot_y_reg) + lga_pkg::WSUM_W'(rot_y_reg);

    always_comb
    begin
        if (wsum_x > lga_pkg::WSUM_W'(lga_pkg::COORD_MAX))
        begin
            wx_next = lga_pkg::COORD_MAX;
        end
        else if (wsum_x < lga_pkg::WSUM_W'(lga_pkg::COORD_MIN))
        begin
            wx_next = lga_pkg::COORD_MIN;
        end
        else
        begin
            wx_next = wsum_x[lga_pkg::COORD_W-1:0];
        end
        if (wsum_y > lga_pkg::WSUM_W'(lga_pkg::COORD_MAX))
        begin
            wy_next = lga_pkg::COORD_MAX;
        end
        else if (wsum_y < lga_pkg::WSUM_W'(lga_pkg::COORD_MIN))
        begin
            wy_next = lga_pkg::COORD_MIN;
        end
        else
        begin
            wy_next = wsum_y[lga_pkg::COORD_W-1:0];
        end
    end

    assign issue = cmd.scan_en && (scan_idx_reg < count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.res_append)
        begin
            lm_mem[count_reg[IDX_W-1:0]] <= {wy_reg, wx_reg};
        end
        if (issue)
        begin
            rdata_reg <= lm_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (cmd.res_append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign dist_sq = lga_pkg::DIST_W'(unsigned'(sqx_reg))
                   + lga_pkg::DIST_W'(unsigned'(sqy_reg));

    always_ff @(posedge clk)
    begin
        idx1_reg <= scan_idx_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        dx_reg   <= lga_pkg::DELTA_W'(wx_reg)
                  - lga_pkg::DELTA_W'($signed(rdata_reg[lga_pkg::COORD_W-1:0]));
        dy_reg   <= lga_pkg::DELTA_W'(wy_reg)
                  - lga_pkg::DELTA_W'($signed(rdata_reg[2*lga_pkg::COORD_W-1:lga_pkg::COORD_W]));
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        hit4_reg <= (dist_sq < lga_pkg::DIST_W'(gate_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_match)
        begin
            matched_reg <= 1'b1;
            added_reg   <= 1'b0;
            full_reg    <= 1'b0;
            slot_reg    <= idx4_reg;
        end
        else if (cmd.res_append)
        begin
            matched_reg <= 1'b0;
            added_reg   <= 1'b1;
            full_reg    <= 1'b0;
            slot_reg    <= count_reg[IDX_W-1:0];
        end
        else if (cmd.res_full)
        begin
            matched_reg <= 1'b0;
            added_reg   <= 1'b0;
            full_reg    <= 1'b1;
            slot_reg    <= '0;
        end
        if (cmd.out_load)
        begin
            out_data_reg  <= {wy_reg, wx_reg, lga_pkg::SLOT_W'(slot_reg)};
            out_flags_reg <= {full_reg, added_reg, matched_reg};
        end
    end

    assign sts.issue_done = (scan_idx_reg >= count_reg);
    assign sts.pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg;
    assign sts.hit        = v4_reg && hit4_reg;
    assign sts.room       = (count_reg < CNT_MAX);

    assign out_data  = out_data_reg;
    assign out_flags = out_flags_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("Landmark count exceeds the table size.");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> !(v1_reg || v2_reg || v3_reg || v4_reg))
        else $error("Scan pipeline not empty after a scan start.");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_append |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("Append did not advance the landmark count.");
`endif

endmodule

@@ sv/landmark_gated_association.sv @@
// ============================================================================
// landmark_gated_association
// Gated first-match association of cone observations against a landmark map.
// ============================================================================
// Input transactions arrive on the s_ channel. With tuser = 0 the item loads
// the robot pose and heading and produces no result. With tuser = 1 the item
// is a cone: its local position is rotated and moved into world coordinates,
// then the stored landmarks are scanned in order, one memory read per cycle
// through a four-stage distance pipeline. The first landmark whose squared
// distance is below the gate matches; without a match the cone is appended,
// or flagged when the table is full. The scan over the landmark memory sets
// the time from acceptance of a cone to its result on the m_ channel, so it
// grows with the number of stored landmarks. One item is in work at a time;
// s_tready is high only while the block idles. The result sits in an output
// register, so a stalled receiver only holds the next cone once its scan has
// finished. The gate register is written on the cfg_ channel, which is always
// ready. Reset empties the table, clears the pose to the origin with zero
// heading and sets the gate to 0.25 square metre; no clearing pass runs over
// the landmark memory.
// ============================================================================
module landmark_gated_association
#(
    parameter int MAX_LANDMARKS = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pose_x, pose_y, heading_cos, heading_sin, cone_local_x, cone_local_y
    input  logic [127:0] s_tdata,
    // opcode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // landmark_slot, world_x, world_y
    output logic [55:0]  m_tdata,
    // matched, added, table_full
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    lga_pkg::cmd_t cmd;
    lga_pkg::sts_t sts;

    lga_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser[0]),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .sts       (sts),
        .cmd       (cmd)
    );

    lga_dp
    #(
        .MAX_LANDMARKS (MAX_LANDMARKS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata),
        .out_flags (m_tuser)
    );

    assign cfg_ready = 1'b1;

endmodule
